/* hdl/spsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsv_pkg
// Shared types and constants for the segmented prime sieve.
// ----------------------------------------------------------------------------
package spsv_pkg;

    // base table builder
    typedef enum logic [2:0] {
        B_CLEAR,
        B_SCAN_RD,
        B_SCAN_WAIT,
        B_STRIKE,
        B_LIST,
        B_DONE
    } base_state_t;

    // window engine
    typedef enum logic [2:0] {
        W_IDLE,
        W_FETCH,
        W_WAIT,
        W_SQ,
        W_CHK,
        W_DIV,
        W_STRIKE,
        W_DONE
    } win_state_t;

    // remainder unit: 32-bit dividend, two quotient bits per cycle
    localparam int DIVIDEND_W = 32;
    localparam int DIV_ITER   = DIVIDEND_W / 2;
    localparam int DIV_CNT_W  = 5;

endpackage

/* hdl/spsv_base.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsv_base
// Builds the base composite table after reset and a packed list of base
// primes; serves the list through a registered read port.
// ----------------------------------------------------------------------------
module spsv_base
    import spsv_pkg::*;
#(
    parameter int BASE_LIMIT = 65536
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    output logic                                         rdy,
    output logic [$clog2(BASE_LIMIT/2+2)-1:0]            prime_count,
    input  logic [$clog2(BASE_LIMIT/2+1)-1:0]            prime_addr,
    output logic [$clog2(BASE_LIMIT)-1:0]                prime_data
);

    localparam int AW  = $clog2(BASE_LIMIT);
    localparam int BW  = AW + 1;
    localparam int PD  = BASE_LIMIT / 2 + 1;
    localparam int PIW = $clog2(PD);
    localparam int PCW = $clog2(PD + 1);

    logic          flag_mem  [BASE_LIMIT];
    logic [AW-1:0] prime_mem [PD];

    base_state_t   state_reg, state_next;
    logic [BW-1:0] i_reg, i_next;
    logic [BW:0]   sq_reg, sq_next;
    logic [BW:0]   j_reg, j_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [AW-1:0] pend_val_reg, pend_val_next;
    logic [PCW-1:0] count_reg;
    logic          flag_q;
    logic [AW-1:0] prime_q;

    logic          fwe;
    logic [AW-1:0] fwaddr;
    logic          fwdata;
    logic [AW-1:0] fraddr;

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        sq_next       = sq_reg;
        j_next        = j_reg;
        pend_vld_next = 1'b0;
        pend_val_next = pend_val_reg;
        fwe           = 1'b0;
        fwaddr        = i_reg[AW-1:0];
        fwdata        = 1'b0;
        fraddr        = i_reg[AW-1:0];
        unique case (state_reg)
            B_CLEAR:
            begin
                fwe    = 1'b1;
                fwdata = (i_reg < BW'(2));
                if (i_reg == BW'(BASE_LIMIT - 1))
                begin
                    i_next     = BW'(2);
                    sq_next    = (BW+1)'(4);
                    state_next = B_SCAN_RD;
                end
                else
                begin
                    i_next = i_reg + BW'(1);
                end
            end
            B_SCAN_RD:
            begin
                if (sq_reg >= (BW+1)'(BASE_LIMIT))
                begin
                    i_next     = BW'(2);
                    state_next = B_LIST;
                end
                else
                begin
                    state_next = B_SCAN_WAIT;
                end
            end
            B_SCAN_WAIT:
            begin
                if (flag_q)
                begin
                    i_next     = i_reg + BW'(1);
                    sq_next    = sq_reg + {i_reg, 1'b1};
                    state_next = B_SCAN_RD;
                end
                else
                begin
                    j_next     = sq_reg;
                    state_next = B_STRIKE;
                end
            end
            B_STRIKE:
            begin
                if (j_reg >= (BW+1)'(BASE_LIMIT))
                begin
                    i_next     = i_reg + BW'(1);
                    sq_next    = sq_reg + {i_reg, 1'b1};
                    state_next = B_SCAN_RD;
                end
                else
                begin
                    fwe    = 1'b1;
                    fwaddr = j_reg[AW-1:0];
                    fwdata = 1'b1;
                    j_next = j_reg + (BW+1)'(i_reg);
                end
            end
            B_LIST:
            begin
                if (i_reg == BW'(BASE_LIMIT))
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    pend_vld_next = 1'b1;
                    pend_val_next = i_reg[AW-1:0];
                    i_next        = i_reg + BW'(1);
                end
            end
            B_DONE:
            begin
                state_next = B_DONE;
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            i_reg        <= '0;
            sq_reg       <= '0;
            j_reg        <= '0;
            pend_vld_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            sq_reg       <= sq_next;
            j_reg        <= j_next;
            pend_vld_reg <= pend_vld_next;
            if (pend_vld_reg && !flag_q)
            begin
                count_reg <= count_reg + PCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
    end

    // flag table: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (fwe)
        begin
            flag_mem[fwaddr] <= fwdata;
        end
        flag_q <= flag_mem[fraddr];
    end

    // prime list
    always_ff @(posedge clk)
    begin
        if (pend_vld_reg && !flag_q)
        begin
            prime_mem[count_reg[PIW-1:0]] <= pend_val_reg;
        end
        prime_q <= prime_mem[prime_addr];
    end

    assign rdy         = (state_reg == B_DONE) && !pend_vld_reg;
    assign prime_count = count_reg;
    assign prime_data  = prime_q;

endmodule

/* hdl/spsv_divmod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsv_divmod
// Iterative remainder of a 32-bit value by a base prime, radix 4.
// ----------------------------------------------------------------------------
module spsv_divmod
    import spsv_pkg::*;
#(
    parameter int PW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [PW-1:0]         divisor,
    output logic                  busy,
    output logic [PW-1:0]         rem
);

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [PW-1:0]         r_reg;
    logic [PW-1:0]         d_reg;
    logic [PW:0]           t1, t2;
    logic [PW-1:0]         r1, r2;

    // two restoring steps; partial remainder stays below the divisor
    always_comb
    begin
        t1 = {r_reg, q_reg[DIVIDEND_W-1]};
        if (t1 >= {1'b0, d_reg})
        begin
            t1 = t1 - {1'b0, d_reg};
        end
        r1 = t1[PW-1:0];
        t2 = {r1, q_reg[DIVIDEND_W-2]};
        if (t2 >= {1'b0, d_reg})
        begin
            t2 = t2 - {1'b0, d_reg};
        end
        r2 = t2[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIVIDEND_W-3:0], 2'b00};
            r_reg <= r2;
        end
    end

    assign busy = busy_reg;
    assign rem  = r_reg;

endmodule

/* hdl/spsv_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsv_window
// Window engine: walks the prime list, finds each first multiple and
// strikes it and its successors out of the window mask.
// ----------------------------------------------------------------------------
module spsv_window
    import spsv_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int BASE_LIMIT = 65536,
    parameter int WINDOW     = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          window_base,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [WINDOW-1:0]                    prime_mask,
    input  logic                                 base_rdy,
    input  logic [$clog2(BASE_LIMIT/2+2)-1:0]    prime_count,
    output logic [$clog2(BASE_LIMIT/2+1)-1:0]    prime_addr,
    input  logic [$clog2(BASE_LIMIT)-1:0]        prime_data
);

    localparam int AW  = $clog2(BASE_LIMIT);
    localparam int PD  = BASE_LIMIT / 2 + 1;
    localparam int PIW = $clog2(PD);
    localparam int PCW = $clog2(PD + 1);
    localparam int WB  = $clog2(WINDOW);
    localparam int OW  = ((AW > 6) ? AW : 6) + 1;
    localparam logic [32:0] MAXV = (33'd1 << VALUE_BITS) - 33'd1;

    win_state_t      state_reg, state_next;
    logic [31:0]     lo_reg, lo_next;
    logic [31:0]     top_reg, top_next;
    logic [WB-1:0]   top_off_reg, top_off_next;
    logic [WINDOW-1:0] mask_reg, mask_next;
    logic [PCW-1:0]  pidx_reg, pidx_next;
    logic [AW-1:0]   p_reg, p_next;
    logic [2*AW-1:0] psq_reg, psq_next;
    logic [OW-1:0]   off_reg, off_next;
    logic            out_vld_reg, out_vld_next;
    logic [WINDOW-1:0] out_mask_reg, out_mask_next;

    logic            div_start;
    logic            div_busy;
    logic [AW-1:0]   div_rem;

    logic [32:0]     v;
    logic [32:0]     tfull;
    logic [32:0]     tclip;
    logic [WINDOW-1:0] init_mask;
    logic [32:0]     psq_ext;
    logic [32:0]     lo_ext;
    logic [AW-1:0]   off_first;
    logic [OW-1:0]   off_sq;
    logic [OW-1:0]   top_off_ext;

    spsv_divmod #(
        .PW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lo_reg),
        .divisor  (p_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    assign s_tready    = (state_reg == W_IDLE) && base_rdy;
    assign prime_addr  = pidx_reg[PIW-1:0];
    assign psq_ext     = 33'(psq_reg);
    assign lo_ext      = {1'b0, lo_reg};
    assign top_off_ext = OW'(top_off_reg);

    // window values in range and at least two
    always_comb
    begin
        init_mask = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            v = {1'b0, window_base} + 33'(k);
            init_mask[k] = (v >= 33'd2) && (v <= MAXV);
        end
        tfull = {1'b0, window_base} + 33'(WINDOW - 1);
        tclip = (tfull > MAXV) ? MAXV : tfull;
    end

    always_comb
    begin
        off_first = (div_rem == '0) ? '0 : (p_reg - div_rem);
        off_sq    = (psq_ext > lo_ext) ? OW'(psq_ext - lo_ext) : '0;
    end

    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        top_next      = top_reg;
        top_off_next  = top_off_reg;
        mask_next     = mask_reg;
        pidx_next     = pidx_reg;
        p_next        = p_reg;
        psq_next      = psq_reg;
        off_next      = off_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_mask_next = out_mask_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    lo_next      = window_base;
                    top_next     = tclip[31:0];
                    top_off_next = WB'(tclip - {1'b0, window_base});
                    mask_next    = init_mask;
                    pidx_next    = '0;
                    state_next   = (init_mask == '0) ? W_DONE : W_FETCH;
                end
            end
            W_FETCH:
            begin
                state_next = (pidx_reg >= prime_count) ? W_DONE : W_WAIT;
            end
            W_WAIT:
            begin
                p_next     = prime_data;
                state_next = W_SQ;
            end
            W_SQ:
            begin
                psq_next   = (2*AW)'(p_reg) * (2*AW)'(p_reg);
                state_next = W_CHK;
            end
            W_CHK:
            begin
                // list is ascending: first square past the top ends the walk
                if (psq_ext > {1'b0, top_reg})
                begin
                    state_next = W_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = W_DIV;
                end
            end
            W_DIV:
            begin
                if (!div_busy)
                begin
                    off_next   = (OW'(off_first) > off_sq) ? OW'(off_first) : off_sq;
                    state_next = W_STRIKE;
                end
            end
            W_STRIKE:
            begin
                if (off_reg > top_off_ext)
                begin
                    pidx_next  = pidx_reg + PCW'(1);
                    state_next = W_FETCH;
                end
                else
                begin
                    mask_next[off_reg[WB-1:0]] = 1'b0;
                    off_next = off_reg + OW'(p_reg);
                end
            end
            W_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_mask_next = mask_reg;
                    state_next    = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= W_IDLE;
            out_vld_reg <= 1'b0;
            pidx_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            pidx_reg    <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        top_reg      <= top_next;
        top_off_reg  <= top_off_next;
        mask_reg     <= mask_next;
        p_reg        <= p_next;
        psq_reg      <= psq_next;
        off_reg      <= off_next;
        out_mask_reg <= out_mask_next;
    end

    assign m_tvalid   = out_vld_reg;
    assign prime_mask = out_mask_reg;

`ifndef ASSERT_OFF
    a_ready_needs_base: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> base_rdy)
        else $error("request taken before base table is built");

    a_strike_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_STRIKE && off_reg <= top_off_ext) |-> (off_reg < OW'(WINDOW)))
        else $error("strike offset outside window");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div_busy && state_reg == W_DIV))
        else $error("remainder unit did not start");
`endif

endmodule

/* hdl/segmented_prime_sieve.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_prime_sieve
// Segmented sieve of Eratosthenes over windows of consecutive values.
// ----------------------------------------------------------------------------
// After reset the block clears a BASE_LIMIT-entry flag memory, sieves it
// (striking the multiples of every prime below the square root of
// BASE_LIMIT) and sweeps it once more into a list of base primes;
// s_tready stays low until then. Each request then carries a window start
// and walks the base primes p with p*p <= window top: every prime costs
// one list read, a square, a remainder (two quotient bits per cycle) and
// its strikes, one mask bit each. A window near 2^32 visits all 6542
// primes. One window is in work at a time; the finished mask sits in an
// output register, so the next request is taken while the previous result
// still waits on m_tready.
// ----------------------------------------------------------------------------
module segmented_prime_sieve
    import spsv_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int BASE_LIMIT = 65536,
    parameter int WINDOW     = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] window_base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] prime_mask
);

    localparam int AW  = $clog2(BASE_LIMIT);
    localparam int PIW = $clog2(BASE_LIMIT / 2 + 1);
    localparam int PCW = $clog2(BASE_LIMIT / 2 + 2);

    logic              base_rdy;
    logic [PCW-1:0]    prime_count;
    logic [PIW-1:0]    prime_addr;
    logic [AW-1:0]     prime_data;
    logic [WINDOW-1:0] mask;

    // base table and prime list
    spsv_base #(
        .BASE_LIMIT (BASE_LIMIT)
    ) u_base (
        .clk         (clk),
        .rst_n       (rst_n),
        .rdy         (base_rdy),
        .prime_count (prime_count),
        .prime_addr  (prime_addr),
        .prime_data  (prime_data)
    );

    // per-window strike engine
    spsv_window #(
        .VALUE_BITS (VALUE_BITS),
        .BASE_LIMIT (BASE_LIMIT),
        .WINDOW     (WINDOW)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .window_base (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .prime_mask  (mask),
        .base_rdy    (base_rdy),
        .prime_count (prime_count),
        .prime_addr  (prime_addr),
        .prime_data  (prime_data)
    );

    // bits at and above WINDOW read as zero
    assign m_tdata = 64'(mask);

endmodule
